[hw/rtl/pec_pkg.sv]
`timescale 1ns / 1ps
package pec_pkg;

	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [28:0] LOG2E_M1 = 29'd475340181;
	localparam logic [35:0] Y_CAP    = 36'h8_0000_0000;

	typedef enum logic [1:0] {
		CFG_DECAY_RATE,
		CFG_SMOOTHNESS_POWER,
		CFG_VARIANCE_SCALE,
		CFG_NUGGET_TERM
	} cfg_index_t;

	typedef struct packed {
		logic [37:0] rem;
		logic [33:0] root;
	} root_step_t;

	// One digit of the restoring square root: two radicand bits in, one root bit out.
	function automatic root_step_t sqrt_step(input logic [37:0] rem, input logic [33:0] root,
		input logic [1:0] two);
		root_step_t r;
		logic [37:0] shifted;
		logic [37:0] trial;
		shifted = {rem[35:0], two};
		trial = {2'b00, root, 2'b01};
		if (shifted >= trial) begin
			r.rem = shifted - trial;
			r.root = {root[32:0], 1'b1};
		end else begin
			r.rem = shifted;
			r.root = {root[32:0], 1'b0};
		end
		return r;
	endfunction

	// Elaboration-time integer square root of a 64-bit value.
	function automatic logic [31:0] isqrt64(input logic [63:0] v);
		logic [65:0] rem;
		logic [65:0] trial;
		logic [31:0] root;
		rem = '0;
		root = '0;
		for (int j = 31; j >= 0; j--) begin
			rem = {rem[63:0], v[2*j+1 -: 2]};
			trial = {32'b0, root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[30:0], 1'b1};
			end else begin
				root = {root[30:0], 1'b0};
			end
		end
		return root;
	endfunction

	// 2^(2^-i) in Q1.30, each root taken from the one before by a floored square root.
	function automatic logic [30:0] exp2_root(input int i);
		logic [31:0] r;
		r = 32'h8000_0000;
		for (int k = 1; k <= i; k++) begin
			r = isqrt64({2'b00, r, 30'b0});
		end
		return r[30:0];
	endfunction

endpackage

[hw/rtl/powered_exponential_covariance_unit.sv]
`timescale 1ns / 1ps
// Powered-exponential covariance: each transaction carries two points of signed Q16.16
// coordinates (the first DIMS of x, y, z are used) and yields sigma^2 * exp(-phi * h^nu) as
// unsigned Q16.16, or sigma^2 + nugget, saturated, when the points coincide. The unit takes
// one transaction per cycle unless the output buffer is full. The pipe holds the 17-stage
// square root, which retires two root bits per stage, and the 30-stage logarithm and the
// two 30-stage power-of-two units, which retire one bit per stage. A two-entry output
// buffer lets a new transaction in while a finished result waits.
// Registers are written through the cfg port.
module powered_exponential_covariance_unit
	import pec_pkg::*;
#(
	parameter int DIMS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (32 bits each, lowest first)
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// covariance [31:0]
	output logic [31:0]  m_axis_tdata,
	// saturated [0]
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NDIM  = (DIMS > 3) ? 3 : DIMS;
	localparam int RT_ST = 17;
	localparam int LG_ST = 30;

	logic [31:0] decay_q;
	logic [15:0] smooth_q;
	logic [31:0] var_q;
	logic [31:0] nug_q;

	logic adv;
	logic push;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= 32'd16777216;
			smooth_q <= 16'd16384;
			var_q    <= 32'd65536;
			nug_q    <= 32'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DECAY_RATE:       decay_q  <= cfg_data;
				CFG_SMOOTHNESS_POWER: smooth_q <= cfg_data[15:0];
				CFG_VARIANCE_SCALE:   var_q    <= cfg_data;
				CFG_NUGGET_TERM:      nug_q    <= cfg_data;
			endcase
		end
	end

	// The whole pipe moves unless the output buffer is full.
	logic out_v_q, skid_v_q;
	assign adv = ~skid_v_q;
	assign s_axis_tready = adv;

	// ---------------- squared differences ----------------
	logic        v_s1;
	logic [65:0] sq_s1 [NDIM];

	for (genvar d = 0; d < NDIM; d++) begin : g_dim
		logic [32:0] diff;
		logic [32:0] mag;
		logic [31:0] pa, pb;
		assign pa   = s_axis_tdata[32*d +: 32];
		assign pb   = s_axis_tdata[32*(d+3) +: 32];
		assign diff = {pa[31], pa} - {pb[31], pb};
		assign mag  = diff[32] ? (33'd0 - diff) : diff;

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s1[d] <= {33'b0, mag} * {33'b0, mag};
			end
		end
	end

	logic [67:0] sum_w;
	logic        v_s2;
	logic [67:0] sum_s2;
	logic        zero_s2;

	always_comb begin
		sum_w = '0;
		for (int d = 0; d < NDIM; d++) begin
			sum_w = sum_w + {2'b00, sq_s1[d]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2  <= sum_w;
			zero_s2 <= (sum_w == '0);
		end
	end

	// ---------------- square root, two digits per stage ----------------
	logic        rt_v_s    [1:RT_ST];
	logic [37:0] rt_rem_s  [1:RT_ST];
	logic [33:0] rt_root_s [1:RT_ST];
	logic [67:0] rt_sum_s  [1:RT_ST];
	logic        rt_zero_s [1:RT_ST];

	logic        rt_v_p    [1:RT_ST];
	logic [37:0] rt_rem_p  [1:RT_ST];
	logic [33:0] rt_root_p [1:RT_ST];
	logic [67:0] rt_sum_p  [1:RT_ST];
	logic        rt_zero_p [1:RT_ST];

	for (genvar g = 1; g <= RT_ST; g++) begin : g_root
		localparam int J1 = 2 * RT_ST + 1 - 2 * g;
		localparam int J0 = 2 * RT_ST - 2 * g;
		root_step_t st_a, st_b;

		if (g == 1) begin : g_head
			assign rt_v_p[g]    = v_s2;
			assign rt_rem_p[g]  = '0;
			assign rt_root_p[g] = '0;
			assign rt_sum_p[g]  = sum_s2;
			assign rt_zero_p[g] = zero_s2;
		end else begin : g_tail
			assign rt_v_p[g]    = rt_v_s[g-1];
			assign rt_rem_p[g]  = rt_rem_s[g-1];
			assign rt_root_p[g] = rt_root_s[g-1];
			assign rt_sum_p[g]  = rt_sum_s[g-1];
			assign rt_zero_p[g] = rt_zero_s[g-1];
		end

		assign st_a = sqrt_step(rt_rem_p[g], rt_root_p[g], rt_sum_p[g][2*J1+1 -: 2]);
		assign st_b = sqrt_step(st_a.rem, st_a.root, rt_sum_p[g][2*J0+1 -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[g] <= 1'b0;
			end else if (adv) begin
				rt_v_s[g] <= rt_v_p[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[g]  <= st_b.rem;
				rt_root_s[g] <= st_b.root;
				rt_sum_s[g]  <= rt_sum_p[g];
				rt_zero_s[g] <= rt_zero_p[g];
			end
		end
	end

	// ---------------- normalise h into [1, 2) ----------------
	logic [33:0] h_w;
	logic [5:0]  k_w;
	logic [33:0] hs_w;
	logic        nm_v_s;
	logic [30:0] nm_m_s;
	logic [5:0]  nm_k_s;
	logic        nm_zero_s;

	assign h_w = rt_root_s[RT_ST];

	always_comb begin
		k_w = '0;
		for (int b = 0; b < 34; b++) begin
			if (h_w[b]) begin
				k_w = 6'(b);
			end
		end
		hs_w = (k_w >= 6'd30) ? (h_w >> (k_w - 6'd30)) : (h_w << (6'd30 - k_w));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_m_s    <= hs_w[30:0];
			nm_k_s    <= k_w;
			nm_zero_s <= rt_zero_s[RT_ST];
		end
	end

	// ---------------- log2 of the mantissa, one bit per stage ----------------
	logic        lg_v_s    [1:LG_ST];
	logic [30:0] lg_x_s    [1:LG_ST];
	logic [29:0] lg_res_s  [1:LG_ST];
	logic [5:0]  lg_k_s    [1:LG_ST];
	logic        lg_zero_s [1:LG_ST];

	logic        lg_v_p    [1:LG_ST];
	logic [30:0] lg_x_p    [1:LG_ST];
	logic [29:0] lg_res_p  [1:LG_ST];
	logic [5:0]  lg_k_p    [1:LG_ST];
	logic        lg_zero_p [1:LG_ST];

	for (genvar i = 1; i <= LG_ST; i++) begin : g_log
		logic [61:0] sqp;
		logic [31:0] x2;

		if (i == 1) begin : g_head
			assign lg_v_p[i]    = nm_v_s;
			assign lg_x_p[i]    = nm_m_s;
			assign lg_res_p[i]  = '0;
			assign lg_k_p[i]    = nm_k_s;
			assign lg_zero_p[i] = nm_zero_s;
		end else begin : g_tail
			assign lg_v_p[i]    = lg_v_s[i-1];
			assign lg_x_p[i]    = lg_x_s[i-1];
			assign lg_res_p[i]  = lg_res_s[i-1];
			assign lg_k_p[i]    = lg_k_s[i-1];
			assign lg_zero_p[i] = lg_zero_s[i-1];
		end

		assign sqp = {31'b0, lg_x_p[i]} * {31'b0, lg_x_p[i]};
		assign x2  = sqp[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_v_s[i] <= 1'b0;
			end else if (adv) begin
				lg_v_s[i] <= lg_v_p[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lg_x_s[i]    <= x2[31] ? x2[31:1] : x2[30:0];
				lg_res_s[i]  <= {lg_res_p[i][28:0], x2[31]};
				lg_k_s[i]    <= lg_k_p[i];
				lg_zero_s[i] <= lg_zero_p[i];
			end
		end
	end

	// ---------------- t = nu * log2 h ----------------
	logic signed [6:0]  kexp_w;
	logic signed [36:0] lg_w;
	logic signed [53:0] tprod_w;
	logic               tt_v_s;
	logic [39:0]        tt_t_s;
	logic               tt_zero_s;

	assign kexp_w  = $signed({1'b0, lg_k_s[LG_ST]}) - 7'sd16;
	assign lg_w    = {kexp_w, lg_res_s[LG_ST]};
	assign tprod_w = 54'($signed({1'b0, smooth_q})) * 54'(lg_w);

	always_ff @(posedge clk) begin
		if (adv) begin
			tt_t_s    <= tprod_w[53:14];
			tt_zero_s <= lg_zero_s[LG_ST];
		end
	end

	// ---------------- h^nu = 2^t ----------------
	logic        ex1_v;
	logic [30:0] ex1_mant;
	logic [10:0] ex1_side;

	pec_exp2 #(
		.SIDE_W(11)
	) u_exp2_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (tt_v_s),
		.frac     (tt_t_s[29:0]),
		.side_in  ({tt_t_s[39:30], tt_zero_s}),
		.out_valid(ex1_v),
		.mant     (ex1_mant),
		.side_out (ex1_side)
	);

	// ---------------- y = phi * h^nu, capped at 32 ----------------
	logic        aa_v_s;
	logic [62:0] aa_a_s;
	logic [9:0]  aa_n_s;
	logic        aa_zero_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_a_s    <= {31'b0, decay_q} * {32'b0, ex1_mant};
			aa_n_s    <= ex1_side[10:1];
			aa_zero_s <= ex1_side[0];
		end
	end

	logic signed [10:0] sft_w;
	logic signed [10:0] neg_w;
	logic [35:0]        lim_w;
	logic [62:0]        shl_w;
	logic [62:0]        shr_w;
	logic [35:0]        y_w;
	logic               yy_v_s;
	logic [35:0]        yy_y_s;
	logic               yy_zero_s;

	assign sft_w = $signed({aa_n_s[9], aa_n_s}) - 11'sd24;

	always_comb begin
		y_w   = '0;
		lim_w = '0;
		shl_w = '0;
		shr_w = '0;
		neg_w = 11'sd0 - sft_w;
		if (!sft_w[10]) begin
			if (sft_w >= 11'sd63) begin
				y_w = Y_CAP;
			end else if (sft_w > 11'sd35) begin
				y_w = (aa_a_s == '0) ? '0 : Y_CAP;
			end else begin
				lim_w = Y_CAP >> sft_w[5:0];
				shl_w = aa_a_s << sft_w[5:0];
				y_w = (aa_a_s > {27'b0, lim_w}) ? Y_CAP : shl_w[35:0];
			end
		end else if (neg_w < 11'sd63) begin
			shr_w = aa_a_s >> neg_w[5:0];
			y_w = (shr_w > {27'b0, Y_CAP}) ? Y_CAP : shr_w[35:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yy_y_s    <= y_w;
			yy_zero_s <= aa_zero_s;
		end
	end

	// ---------------- e = y * log2(e), split into shift and fraction ----------------
	logic [64:0] eprod_w;
	logic [36:0] e_w;
	logic [29:0] r_w;
	logic [6:0]  q_w;
	logic [30:0] rneg_w;
	logic        ee_v_s;
	logic [29:0] ee_f_s;
	logic [7:0]  ee_shift_s;
	logic        ee_zero_s;

	assign eprod_w = {29'b0, yy_y_s} * {36'b0, LOG2E_M1};
	assign e_w     = {1'b0, yy_y_s} + {2'b00, eprod_w[64:30]};
	assign q_w     = e_w[36:30];
	assign r_w     = e_w[29:0];
	assign rneg_w  = Q30_ONE - {1'b0, r_w};

	always_ff @(posedge clk) begin
		if (adv) begin
			ee_f_s     <= (r_w == '0) ? '0 : rneg_w[29:0];
			ee_shift_s <= (r_w == '0) ? (8'd30 + {1'b0, q_w}) : (8'd31 + {1'b0, q_w});
			ee_zero_s  <= yy_zero_s;
		end
	end

	logic       ex2_v;
	logic [30:0] ex2_mant;
	logic [8:0]  ex2_side;

	pec_exp2 #(
		.SIDE_W(9)
	) u_exp2_decay (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (ee_v_s),
		.frac     (ee_f_s),
		.side_in  ({ee_shift_s, ee_zero_s}),
		.out_valid(ex2_v),
		.mant     (ex2_mant),
		.side_out (ex2_side)
	);

	// ---------------- scale by sigma^2 ----------------
	logic        pp_v_s;
	logic [62:0] pp_prod_s;
	logic [7:0]  pp_shift_s;
	logic        pp_zero_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_prod_s  <= {31'b0, var_q} * {32'b0, ex2_mant};
			pp_shift_s <= ex2_side[8:1];
			pp_zero_s  <= ex2_side[0];
		end
	end

	logic [32:0] vsum_w;
	logic [62:0] scaled_w;
	logic [31:0] cov_w;
	logic        sat_w;
	logic        res_v_s;
	logic [31:0] res_cov_s;
	logic        res_sat_s;

	assign vsum_w   = {1'b0, var_q} + {1'b0, nug_q};
	assign scaled_w = pp_prod_s >> pp_shift_s[5:0];

	always_comb begin
		if (pp_zero_s) begin
			cov_w = vsum_w[32] ? 32'hFFFF_FFFF : vsum_w[31:0];
			sat_w = vsum_w[32];
		end else begin
			cov_w = (pp_shift_s >= 8'd64) ? 32'd0 : scaled_w[31:0];
			sat_w = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_cov_s <= cov_w;
			res_sat_s <= sat_w;
		end
	end

	// ---------------- valid bits of the single-register stages ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			nm_v_s  <= 1'b0;
			tt_v_s  <= 1'b0;
			aa_v_s  <= 1'b0;
			yy_v_s  <= 1'b0;
			ee_v_s  <= 1'b0;
			pp_v_s  <= 1'b0;
			res_v_s <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_axis_tvalid;
			v_s2    <= v_s1;
			nm_v_s  <= rt_v_s[RT_ST];
			tt_v_s  <= lg_v_s[LG_ST];
			aa_v_s  <= ex1_v;
			yy_v_s  <= aa_v_s;
			ee_v_s  <= yy_v_s;
			pp_v_s  <= ex2_v;
			res_v_s <= pp_v_s;
		end
	end

	// ---------------- output register and skid entry ----------------
	logic [31:0] out_cov_q, skid_cov_q;
	logic        out_sat_q, skid_sat_q;

	assign push = adv & res_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_cov_q <= skid_cov_q;
				out_sat_q <= skid_sat_q;
			end else begin
				out_cov_q <= res_cov_s;
				out_sat_q <= res_sat_s;
			end
		end else if (push) begin
			skid_cov_q <= res_cov_s;
			skid_sat_q <= res_sat_s;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_cov_q;
	assign m_axis_tuser  = out_sat_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("skid entry filled without a stalled output");

	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'hFFFF_FFFF)
		else $error("saturated result is not the maximum value");

endmodule

[hw/rtl/pec_exp2.sv]
`timescale 1ns / 1ps
module pec_exp2
	import pec_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [29:0]       frac,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [30:0]       mant,
	output logic [SIDE_W-1:0] side_out
);

	localparam int STAGES = 30;

	logic              v_s    [1:STAGES];
	logic [30:0]       acc_s  [1:STAGES];
	logic [29:0]       frac_s [1:STAGES];
	logic [SIDE_W-1:0] side_s [1:STAGES];

	logic              v_p    [1:STAGES];
	logic [30:0]       acc_p  [1:STAGES];
	logic [29:0]       frac_p [1:STAGES];
	logic [SIDE_W-1:0] side_p [1:STAGES];

	// Stage i multiplies in the root for fraction bit 30-i when that bit is set.
	for (genvar i = 1; i <= STAGES; i++) begin : g_stage
		localparam logic [30:0] ROOT = exp2_root(i);
		logic [61:0] prod;

		if (i == 1) begin : g_head
			assign v_p[i]    = in_valid;
			assign acc_p[i]  = Q30_ONE;
			assign frac_p[i] = frac;
			assign side_p[i] = side_in;
		end else begin : g_tail
			assign v_p[i]    = v_s[i-1];
			assign acc_p[i]  = acc_s[i-1];
			assign frac_p[i] = frac_s[i-1];
			assign side_p[i] = side_s[i-1];
		end

		assign prod = {31'b0, acc_p[i]} * {31'b0, ROOT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[i]  <= frac_p[i][STAGES-i] ? prod[60:30] : acc_p[i];
				frac_s[i] <= frac_p[i];
				side_s[i] <= side_p[i];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign mant      = acc_s[STAGES];
	assign side_out  = side_s[STAGES];

	// Every root is at least one, so the product never drops below one.
	a_mant_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mant[30])
		else $error("exp2 mantissa below one");

endmodule

[dv/powered_exponential_covariance_checker.sv]
`timescale 1ns / 1ps
module powered_exponential_covariance_checker
	import pec_pkg::*;
#(
	parameter int DIMS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           mismatches,
	output int           pending
);

	typedef struct {
		logic [31:0] covariance;
		logic        saturated;
	} cov_result_t;

	logic [31:0] phi_q8_24;
	logic [15:0] nu_q2_14;
	logic [31:0] sigma_sq;
	logic [31:0] nugget;
	cov_result_t expected_cov[$];

	// Floored square root of a radicand up to 68 bits, two bits per step.
	function automatic logic [63:0] floor_sqrt(input logic [67:0] v, input int pairs);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] trial;
		rem = '0;
		root = '0;
		for (int j = pairs - 1; j >= 0; j--) begin
			rem = {rem[61:0], v[2*j +: 2]};
			trial = {root[61:0], 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[62:0], 1'b1};
			end else begin
				root = {root[62:0], 1'b0};
			end
		end
		return root;
	endfunction

	// 2^(f / 2^30) in Q1.30 as a product of successive square roots of two.
	function automatic logic [63:0] pow2_fraction(input logic [63:0] f);
		logic [63:0] acc;
		logic [63:0] root;
		acc = 64'd1 << 30;
		root = 64'd2 << 30;
		for (int i = 1; i <= 30; i++) begin
			root = floor_sqrt({4'b0, root << 30}, 32);
			if (f[30-i])
				acc = (acc * root) >> 30;
		end
		return acc;
	endfunction

	// log2 of a mantissa in [1, 2) held as Q1.30, by repeated squaring.
	function automatic logic [63:0] log2_mantissa(input logic [63:0] m);
		logic [63:0] x;
		logic [63:0] res;
		x = m;
		res = '0;
		for (int i = 1; i <= 30; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				res[30-i] = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic cov_result_t predict_covariance(input logic [191:0] pair);
		cov_result_t r;
		logic [67:0] dist_sq;
		longint      diff;
		logic [63:0] mag;
		logic [63:0] h;
		logic [63:0] m;
		logic [63:0] mant;
		logic [63:0] scaled;
		logic [63:0] y;
		logic [63:0] e;
		logic [63:0] q;
		logic [63:0] frac_r;
		logic [63:0] factor;
		logic [32:0] zero_sum;
		longint      lg;
		longint      t;
		longint      n;
		longint      sh;
		int          k;
		int          shift;
		dist_sq = '0;
		for (int i = 0; i < DIMS && i < 3; i++) begin
			diff = longint'($signed(pair[32*i +: 32])) - longint'($signed(pair[32*(i+3) +: 32]));
			mag = (diff < 0) ? -diff : diff;
			dist_sq = dist_sq + 68'(mag * mag);
		end
		if (dist_sq == '0) begin
			zero_sum = {1'b0, sigma_sq} + {1'b0, nugget};
			r.saturated = zero_sum[32];
			r.covariance = zero_sum[32] ? 32'hFFFF_FFFF : zero_sum[31:0];
			return r;
		end
		h = floor_sqrt(dist_sq, 34);
		k = 0;
		for (int b = 0; b < 64; b++)
			if (h[b]) k = b;
		m = (k >= 30) ? (h >> (k - 30)) : (h << (30 - k));
		lg = longint'(k - 16) * (longint'(1) << 30) + longint'(log2_mantissa(m));
		t = (longint'(nu_q2_14) * lg) >>> 14;
		n = t >>> 30;
		mant = pow2_fraction(64'(t - (n <<< 30)));
		scaled = 64'(phi_q8_24) * mant;
		if (n - 24 >= 0) begin
			sh = n - 24;
			if (sh >= 63 || scaled > (64'(Y_CAP) >> sh))
				y = 64'(Y_CAP);
			else
				y = scaled << sh;
		end else begin
			sh = 24 - n;
			y = (sh >= 64) ? '0 : (scaled >> sh);
		end
		if (y > 64'(Y_CAP))
			y = 64'(Y_CAP);
		e = y + ((y * 64'(LOG2E_M1)) >> 30);
		q = e >> 30;
		frac_r = e & ((64'd1 << 30) - 1);
		if (frac_r == 0) begin
			factor = 64'd1 << 30;
			shift = 30 + int'(q);
		end else begin
			factor = pow2_fraction((64'd1 << 30) - frac_r);
			shift = 31 + int'(q);
		end
		r.covariance = (shift >= 64) ? '0 : 32'((64'(sigma_sq) * factor) >> shift);
		r.saturated = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] covariance check: %s", $time, what);
		mismatches++;
	endtask

	assign pending = expected_cov.size();

	always @(posedge clk or negedge arst_n) begin
		cov_result_t want;
		if (!arst_n) begin
			phi_q8_24 <= 32'd16777216;
			nu_q2_14 <= 16'd16384;
			sigma_sq <= 32'd65536;
			nugget <= 32'd0;
			mismatches = 0;
			expected_cov.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_DECAY_RATE:       phi_q8_24 <= cfg_data;
					CFG_SMOOTHNESS_POWER: nu_q2_14 <= cfg_data[15:0];
					CFG_VARIANCE_SCALE:   sigma_sq <= cfg_data;
					CFG_NUGGET_TERM:      nugget <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_cov.push_back(predict_covariance(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_cov.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					want = expected_cov.pop_front();
					if (m_axis_tdata !== want.covariance)
						report_mismatch($sformatf("covariance %h, want %h", m_axis_tdata,
							want.covariance));
					if (m_axis_tuser !== want.saturated)
						report_mismatch($sformatf("saturated %b, want %b", m_axis_tuser,
							want.saturated));
				end
			end
		end
	end

endmodule

[dv/powered_exponential_covariance_unit_test.sv]
`timescale 1ns / 1ps
module powered_exponential_covariance_unit_test;
	import pec_pkg::*;

	localparam int DIMS = 2;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 140;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           mismatches;
	int           pending;
	int           cycles = 0;
	bit           idling_on;
	bit           hold_request;
	bit           hold_done = 1'b0;
	int           hold_left = 0;

	powered_exponential_covariance_unit #(.DIMS(DIMS)) u_top (.*);

	powered_exponential_covariance_checker #(.DIMS(DIMS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left <= 600;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idling_on && $urandom_range(99) < 26);
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		logic ready_seen;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (!ready_seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_kernel(input logic [31:0] phi, input logic [31:0] nu,
		input logic [31:0] sigma, input logic [31:0] nug);
		write_reg(CFG_DECAY_RATE, phi);
		write_reg(CFG_SMOOTHNESS_POWER, nu);
		write_reg(CFG_VARIANCE_SCALE, sigma);
		write_reg(CFG_NUGGET_TERM, nug);
	endtask

	task automatic send_pair(input logic [191:0] pair);
		logic ready_seen;
		while (idling_on && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pair;
		do begin
			@(negedge clk);
			ready_seen = s_axis_tready;
			@(posedge clk);
		end while (!ready_seen);
	endtask

	// Waits until every expected result has come back, then lets the pipeline settle.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord(input logic [31:0] base, input int spread);
		return base + 32'($urandom_range(2 * spread) - spread);
	endfunction

	function automatic logic [191:0] random_pair;
		logic [31:0] a[3];
		logic [31:0] b[3];
		int          kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			a[i] = $urandom;
			case (kind)
				0:       b[i] = (i < DIMS) ? a[i] : $urandom;
				1, 2:    b[i] = near_coord(a[i], 4);
				3, 4, 5: b[i] = near_coord(a[i], 1 << $urandom_range(4, 20));
				default: b[i] = $urandom;
			endcase
		end
		return {b[2], b[1], b[0], a[2], a[1], a[0]};
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_pair(random_pair());
	endtask

	initial begin
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] one;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idling_on = 1'b1;
		hold_request = 1'b0;
		lo = 32'h8000_0000;
		hi = 32'h7FFF_FFFF;
		one = 32'h0001_0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: coincident points, the unused third axis, extreme and tiny distances.
		send_pair('0);
		send_pair({32'd5, 64'd0, 32'd9, 64'd0});
		send_pair({hi, hi, hi, lo, lo, lo});
		send_pair({lo, lo, lo, hi, hi, hi});
		send_pair({64'd0, 32'd1, 64'd0, 32'd0});
		send_pair({32'd0, 32'd1, 32'd0, 64'd0, 32'd0});
		send_pair({64'd0, one, 96'd0});
		send_pair({32'd0, one, one, 96'd0});
		send_pair({64'd0, 32'h0010_0000, 96'd0});
		send_pair({64'd0, 32'hFFFF_FFFF, 64'd0, 32'hFFFF_FFFF});
		drain();
		// Zero decay and zero smoothness with saturating variance plus nugget.
		set_kernel(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair('0);
		send_pair({hi, hi, hi, lo, lo, lo});
		send_pair({64'd0, 32'd3, 96'd0});
		drain();
		// Largest decay and a smoothness of 2.0: the exponent cap and a vanishing result.
		set_kernel(32'hFFFF_FFFF, 32'd32768, 32'hFFFF_FFFF, 32'd1);
		send_pair('0);
		send_pair({hi, hi, hi, lo, lo, lo});
		send_pair({64'd0, 32'd1, 96'd0});
		send_pair({64'd0, one, 96'd0});
		drain();
		write_reg(CFG_SMOOTHNESS_POWER, 32'h0000_FFFF);
		send_pair({64'd0, 32'd1, 96'd0});
		send_pair({64'd0, 32'h0000_8000, 96'd0});
		drain();

		set_kernel(32'd16777216, 32'd16384, 32'd65536, 32'd0);
		run_random(250);
		// Long hold-off on the result side while pairs keep coming.
		hold_request = 1'b1;
		run_random(200);
		hold_request = 1'b0;
		drain();

		set_kernel(32'h0008_0000, 32'd8192, 32'h0100_0000, 32'h0000_8000);
		idling_on = 1'b0;
		run_random(300);
		idling_on = 1'b1;
		drain();

		set_kernel(32'h0000_0100, 32'd32768, 32'hFFFF_FFFF, 32'h8000_0000);
		run_random(250);
		drain();

		set_kernel($urandom, $urandom_range(32768), $urandom, $urandom);
		run_random(250);
		drain();

		set_kernel(32'h4000_0000, 32'd1, 32'd1, 32'hFFFF_FFFF);
		run_random(200);
		drain();

		set_kernel($urandom, $urandom_range(32768), $urandom, $urandom);
		run_random(250);
		drain();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
